[hw/rtl/psk_pkg.sv]
// Package for the two-dimensional skyline block: sizes, payload beat types
// and the stored-point layout. No dependencies.
package psk_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 16;
    localparam int ENTRY_W    = 2 * COORD_W;

    typedef logic [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord point_distance;
        t_coord point_cost;
        logic   final_point;
    } t_point;

    typedef struct packed {
        t_coord front_distance;
        t_coord front_cost;
        logic   front_last;
        logic   overflowed;
    } t_front;

    // One stored entry; distance in the upper half.
    typedef struct packed {
        t_coord distance;
        t_coord cost;
    } t_entry;

    // Search state handed to the shared compare unit.
    typedef struct packed {
        logic   bound_en;
        t_coord bound_dist;
        logic   found;
        t_coord best_dist;
        t_coord best_cost;
    } t_search;

endpackage

[hw/rtl/pareto_skyline_2d.sv]
// Top level of the two-dimensional skyline (Pareto minima) block.
// Depends on psk_pkg, psk_ram and psk_cmp.
//
// Points stream in one beat per cycle and are written into a 64-entry point
// store; a beat with final_point set closes the set. Points beyond the store
// depth are dropped and every result of that set then carries overflowed.
// After the closing beat the block stalls its input and searches the store
// with one compare unit, one entry per cycle through the store's single
// read port: each pass picks the lowest-cost point (ties: lowest distance)
// whose distance is below that of the previous front point. A pass reads
// every stored point and then hands its result over, and a front of F
// points takes F + 1 passes; the result channel can stall the handover.
// Front points leave in ascending cost, the last one flagged with
// front_last; each result is held one pass so that the flag is known when
// it is sent. Non-closing points are taken back to back with no stall.
module pareto_skyline_2d (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  psk_pkg::t_point i_point,
    output logic            o_valid,
    input  logic            i_stall,
    output psk_pkg::t_front o_front
);
    import psk_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;      // points stored for this set
    logic              r_ovf;        // a point of this set was dropped
    logic [CNT_W-1:0]  r_addr;       // next store address to read
    logic              r_rd_vld;     // read data arrives this cycle
    logic              r_rd_last;    // ... and it is the last entry
    t_search           r_search;     // bound and best of the current pass
    logic              r_pend_vld;   // front point waiting for its last flag
    t_entry            r_pend;
    logic              r_out_vld;
    t_front            r_out;

    logic              w_accept;
    logic              w_store;
    logic              w_full;
    logic              w_issue;
    logic              w_take;
    logic              w_slot;
    logic [CNT_W-1:0]  n_addr;
    logic [ENTRY_W-1:0] w_rdata;
    t_entry            w_entry;
    t_entry            w_wentry;

    assign w_full   = (r_count == CNT_W'(MAX_POINTS));
    assign w_accept = i_valid && !o_stall;
    assign w_store  = w_accept && !w_full;
    assign w_issue  = (r_state == ST_SCAN) && (r_addr != r_count);
    assign n_addr   = r_addr + CNT_W'(1);
    assign w_slot   = !r_out_vld || !i_stall;

    assign w_wentry.distance = i_point.point_distance;
    assign w_wentry.cost     = i_point.point_cost;
    assign w_entry           = t_entry'(w_rdata);

    psk_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (ENTRY_W'(w_wentry)),
        .i_raddr (r_addr[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    psk_cmp u_cmp (
        .i_entry  (w_entry),
        .i_search (r_search),
        .o_take   (w_take)
    );

    // Control and search sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_addr     <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_last  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_search   <= '0;
        end else begin
            r_rd_vld  <= w_issue;
            r_rd_last <= w_issue && (n_addr == r_count);
            if (w_issue) begin
                r_addr <= n_addr;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        // Store the point, or drop it when the store is full.
                        if (w_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        if (i_point.final_point) begin
                            r_addr     <= '0;
                            r_search   <= '0;
                            r_pend_vld <= 1'b0;
                            r_state    <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_rd_vld && w_take) begin
                        r_search.found     <= 1'b1;
                        r_search.best_dist <= w_entry.distance;
                        r_search.best_cost <= w_entry.cost;
                    end
                    if (r_rd_vld && r_rd_last) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (r_search.found) begin
                        // Hold the new front point; release the older one.
                        if (!r_pend_vld || w_slot) begin
                            r_pend_vld          <= 1'b1;
                            r_pend.distance     <= r_search.best_dist;
                            r_pend.cost         <= r_search.best_cost;
                            r_search.bound_en   <= 1'b1;
                            r_search.bound_dist <= r_search.best_dist;
                            r_search.found      <= 1'b0;
                            r_addr              <= '0;
                            r_state             <= ST_SCAN;
                        end
                    end else if (w_slot) begin
                        // Nothing left: the held point closes the front.
                        r_pend_vld <= 1'b0;
                        r_count    <= '0;
                        r_ovf      <= 1'b0;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Output register: load a held front point when the slot frees up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_slot && (r_state == ST_EMIT) && r_pend_vld) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot && (r_state == ST_EMIT) && r_pend_vld) begin
            r_out.front_distance <= r_pend.distance;
            r_out.front_cost     <= r_pend.cost;
            r_out.front_last     <= !r_search.found;
            r_out.overflowed     <= r_ovf;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_vld;
    assign o_front = r_out;

endmodule

[hw/rtl/psk_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/psk_cmp.sv]
// Shared compare unit: decides whether a stored entry replaces the current
// best candidate of a front-search pass. Depends on psk_pkg.
module psk_cmp (
    input  psk_pkg::t_entry  i_entry,
    input  psk_pkg::t_search i_search,
    output logic             o_take
);
    import psk_pkg::*;

    logic w_in_bound;
    logic w_better;

    // Candidate must lie left of the previous front point, and beat the
    // current best on cost, then on distance.
    assign w_in_bound = !i_search.bound_en || (i_entry.distance < i_search.bound_dist);
    assign w_better   = !i_search.found
                     || (i_entry.cost < i_search.best_cost)
                     || ((i_entry.cost == i_search.best_cost)
                         && (i_entry.distance < i_search.best_dist));
    assign o_take     = w_in_bound && w_better;

endmodule

[tb/tb_pareto_skyline_2d.sv]
// Self-checking testbench for pareto_skyline_2d: streams point sets through the
// input channel, predicts the Pareto front of each set and checks every result.
// Depends on psk_pkg and the pareto_skyline_2d RTL.
`timescale 1ns / 100ps

module tb_pareto_skyline_2d;

    import psk_pkg::*;

    // Style codes for generated point sets.
    localparam int SET_WIDE   = 0;   // full-range random coordinates
    localparam int SET_NARROW = 1;   // tiny value range, lots of ties and duplicates
    localparam int SET_STAIR  = 2;   // every point on the front, shuffled
    localparam int SET_EDGE   = 3;   // mostly corner values of the coordinate range

    localparam int RESET_CYCLES = 10;
    localparam int CALM_TAIL    = 30;      // last beats run with no idling at all
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 400000;

    logic   clk   = 1'b0;
    logic   rst_n = 1'b0;

    logic   pt_valid = 1'b0;
    logic   pt_stall;
    t_point pt_beat  = '0;
    logic   fr_valid;
    logic   fr_stall = 1'b0;
    t_front fr_beat;

    // Points waiting to be driven, and front points waiting to come back.
    t_point pend_q[$];
    t_front front_q[$];

    // Predictor copy of the point store.
    t_coord store_dist[MAX_POINTS];
    t_coord store_cost[MAX_POINTS];
    int     store_cnt = 0;
    logic   store_ovf = 1'b0;

    int n_items    = 0;
    int n_taken    = 0;
    int n_sets     = 0;
    int n_ovf_sets = 0;
    int n_fronts   = 0;
    int n_errors   = 0;
    int cycle_cnt  = 0;
    int in_gap     = 0;
    int out_hold   = 0;

    pareto_skyline_2d i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (pt_valid),
        .o_stall (pt_stall),
        .i_point (pt_beat),
        .o_valid (fr_valid),
        .i_stall (fr_stall),
        .o_front (fr_beat)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 0;
    end

    // Absorb one accepted point; on the closing point compute the front
    // and queue it in ascending cost order.
    task automatic skyline_absorb(input t_point p);
        t_coord sd [MAX_POINTS];
        t_coord sc [MAX_POINTS];
        t_coord td;
        t_coord tc;
        t_coord low_cost;
        t_front kept_q[$];
        t_front f;
        int     j;
        if (store_cnt < MAX_POINTS) begin
            store_dist[store_cnt] = p.point_distance;
            store_cost[store_cnt] = p.point_cost;
            store_cnt++;
        end else begin
            store_ovf = 1'b1;
        end
        if (!p.final_point)
            return;
        // Sort by distance, then cost, ascending.
        for (int i = 0; i < store_cnt; i++) begin
            td = store_dist[i];
            tc = store_cost[i];
            j  = i;
            while (j > 0 && (sd[j-1] > td || (sd[j-1] == td && sc[j-1] > tc))) begin
                sd[j] = sd[j-1];
                sc[j] = sc[j-1];
                j--;
            end
            sd[j] = td;
            sc[j] = tc;
        end
        // Keep a point only if its cost beats every earlier one; pushing to the
        // front flips the falling-cost scan into ascending cost.
        low_cost = '0;
        for (int i = 0; i < store_cnt; i++) begin
            if (kept_q.size() == 0 || sc[i] < low_cost) begin
                f.front_distance = sd[i];
                f.front_cost     = sc[i];
                f.front_last     = 1'b0;
                f.overflowed     = store_ovf;
                kept_q.push_front(f);
                low_cost = sc[i];
            end
        end
        kept_q[kept_q.size() - 1].front_last = 1'b1;
        foreach (kept_q[k])
            front_q.insert(front_q.size(), kept_q[k]);
        n_sets++;
        if (store_ovf)
            n_ovf_sets++;
        store_cnt = 0;
        store_ovf = 1'b0;
    endtask

    task automatic add_point(input t_coord d, input t_coord c, input logic fin);
        t_point p;
        p.point_distance = d;
        p.point_cost     = c;
        p.final_point    = fin;
        pend_q.insert(pend_q.size(), p);
    endtask

    function automatic t_coord edge_value();
        case ($urandom_range(0, 4))
            0: edge_value = 16'h0000;
            1: edge_value = 16'hFFFF;
            2: edge_value = 16'h0001;
            3: edge_value = 16'hFFFE;
            default: edge_value = t_coord'($urandom);
        endcase
    endfunction

    // Queue one set of n points in the given style; the last one closes it.
    task automatic queue_set(input int n, input int style);
        t_coord sd[$];
        t_coord sc[$];
        t_coord tmp;
        t_coord vd;
        t_coord vc;
        int     span;
        int     j;
        span = 65536 / (n + 1);
        for (int i = 0; i < n; i++) begin
            case (style)
                SET_NARROW: begin
                    vd = t_coord'($urandom_range(0, 7));
                    vc = t_coord'($urandom_range(0, 7));
                end
                SET_STAIR: begin
                    vd = t_coord'(i * span + $urandom_range(0, span - 1));
                    vc = t_coord'((n - 1 - i) * span + $urandom_range(0, span - 1));
                end
                SET_EDGE: begin
                    vd = edge_value();
                    vc = edge_value();
                end
                default: begin
                    vd = t_coord'($urandom);
                    vc = t_coord'($urandom);
                end
            endcase
            sd.insert(sd.size(), vd);
            sc.insert(sc.size(), vc);
        end
        // Shuffle so the arrival order says nothing about the sorted order.
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = sd[i]; sd[i] = sd[j]; sd[j] = tmp;
            tmp = sc[i]; sc[i] = sc[j]; sc[j] = tmp;
        end
        for (int i = 0; i < n; i++)
            add_point(sd[i], sc[i], i == n - 1);
    endtask

    task automatic queue_small_sets(input int upto);
        int n;
        while (pend_q.size() < upto) begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            queue_set(n, $urandom_range(SET_WIDE, SET_EDGE));
        end
    endtask

    // Driver: predict on every accepted beat, then load the next point or idle.
    // A stalled beat is held untouched.
    always @(posedge clk) begin
        if (!rst_n) begin
            pt_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (pt_valid && !pt_stall) begin
                skyline_absorb(pt_beat);
                n_taken++;
            end
            if (!pt_valid || !pt_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    pt_valid <= 1'b0;
                end else if (pend_q.size() == 0) begin
                    pt_valid <= 1'b0;
                end else if (pend_q.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
                    // Open an idle burst; in_gap holds what is left of it.
                    in_gap = $urandom_range(0, 2);
                    pt_valid <= 1'b0;
                end else begin
                    pt_beat  <= pend_q.pop_front();
                    pt_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest expectation,
    // and stall the result channel in short random bursts.
    always @(posedge clk) begin
        t_front want;
        if (!rst_n) begin
            fr_stall <= 1'b0;
            out_hold = 0;
        end else begin
            if (fr_valid && !fr_stall) begin
                if (front_q.size() == 0) begin
                    $error("unexpected front point: distance %h cost %h last %b ovf %b",
                           fr_beat.front_distance, fr_beat.front_cost,
                           fr_beat.front_last, fr_beat.overflowed);
                    n_errors++;
                end else begin
                    want = front_q.pop_front();
                    n_fronts++;
                    if (fr_beat.front_distance !== want.front_distance) begin
                        $error("front_distance: expected %h, got %h",
                               want.front_distance, fr_beat.front_distance);
                        n_errors++;
                    end
                    if (fr_beat.front_cost !== want.front_cost) begin
                        $error("front_cost: expected %h, got %h",
                               want.front_cost, fr_beat.front_cost);
                        n_errors++;
                    end
                    if (fr_beat.front_last !== want.front_last) begin
                        $error("front_last: expected %b, got %b",
                               want.front_last, fr_beat.front_last);
                        n_errors++;
                    end
                    if (fr_beat.overflowed !== want.overflowed) begin
                        $error("overflowed: expected %b, got %b",
                               want.overflowed, fr_beat.overflowed);
                        n_errors++;
                    end
                end
            end
            if (out_hold > 0) begin
                out_hold--;
                fr_stall <= 1'b1;
            end else if (pend_q.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
                out_hold = $urandom_range(0, 2);
                fr_stall <= 1'b1;
            end else begin
                fr_stall <= 1'b0;
            end
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_pareto_skyline_2d: errors");
            $finish;
        end
    end

    initial begin
        // Directed sets first: coordinate extremes, a full three-point front,
        // exact duplicates, ties on distance, ties on cost, dominated points
        // and alternating bit patterns.
        add_point(16'h0000, 16'h0000, 1'b1);
        add_point(16'hFFFF, 16'hFFFF, 1'b1);
        add_point(16'hFFFF, 16'h0000, 1'b0);
        add_point(16'h0000, 16'hFFFF, 1'b0);
        add_point(16'h8000, 16'h8000, 1'b1);
        add_point(16'h0005, 16'h0005, 1'b0);
        add_point(16'h0005, 16'h0005, 1'b0);
        add_point(16'h0005, 16'h0005, 1'b1);
        add_point(16'h0003, 16'h0009, 1'b0);
        add_point(16'h0003, 16'h0004, 1'b0);
        add_point(16'h0003, 16'h0007, 1'b1);
        add_point(16'h0009, 16'h0002, 1'b0);
        add_point(16'h0004, 16'h0002, 1'b0);
        add_point(16'h0006, 16'h0002, 1'b1);
        add_point(16'h0001, 16'h0001, 1'b0);
        add_point(16'h0002, 16'h0002, 1'b0);
        add_point(16'h0003, 16'h0003, 1'b0);
        add_point(16'h0000, 16'h0009, 1'b1);
        add_point(16'hAAAA, 16'h5555, 1'b0);
        add_point(16'h5555, 16'hAAAA, 1'b1);

        // Random part: mostly small sets, one full store with every point on
        // the front, and one set that overflows (its closing point dropped too).
        queue_small_sets(80);
        queue_set(MAX_POINTS, SET_STAIR);
        queue_small_sets(190);
        queue_set(MAX_POINTS + 3, SET_WIDE);
        queue_small_sets(310);
        n_items = pend_q.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every point to be taken, then for every front point.
        while (n_taken < n_items || front_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Fed %0d points in %0d sets (%0d with overflow); checked %0d front points.",
                 n_items, n_sets, n_ovf_sets, n_fronts);
        if (n_errors == 0 && front_q.size() == 0) begin
            $display("tb_pareto_skyline_2d: clean");
        end else begin
            $display("tb_pareto_skyline_2d: errors");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/psk_pkg.sv
hw/rtl/psk_ram.sv
hw/rtl/psk_cmp.sv
hw/rtl/pareto_skyline_2d.sv
tb/tb_pareto_skyline_2d.sv
